// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the endpoint identifier hash table.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define EHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define EHT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/eht_pkg.sv =====
// Package for the endpoint identifier hash table: key type, codes and widths.
// No dependencies; used by the channel interfaces and every module.
`timescale 1ns / 1ps

package eht_pkg;

   localparam int KEY_BYTES   = 20;
   localparam int BUCKETS     = 256;
   localparam int BUCKET_BITS = 8;
   localparam int HANDLE_W    = 16;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

   typedef struct packed {
      logic [31:0] top;
      logic [63:0] mid;
      logic [63:0] low;
   } eht_key_type;

endpackage

// ===== hw/rtl/eht_channels.sv =====
// Request and response channel interfaces of the endpoint identifier hash table.
// Depends on eht_pkg for field widths.
`timescale 1ns / 1ps

interface eht_req_if;
   import eht_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [63:0]         key_low;
   logic [63:0]         key_mid;
   logic [31:0]         key_top;
   logic [HANDLE_W-1:0] handle_in;

   modport source (output valid, cmd, key_low, key_mid, key_top, handle_in, input ready);
   modport sink (input valid, cmd, key_low, key_mid, key_top, handle_in, output ready);
endinterface

interface eht_rsp_if;
   import eht_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic [HANDLE_W-1:0] handle_out;
   logic [STATUS_W-1:0] status;

   modport source (output valid, found, handle_out, status, input ready);
   modport sink (input valid, found, handle_out, status, output ready);
endinterface

// ===== hw/rtl/eht_hash.sv =====
// Bucket hash: the XOR of all twenty key bytes.
// Depends on eht_pkg for the key type and bucket width.
`timescale 1ns / 1ps

module eht_hash (
   input  eht_pkg::eht_key_type            key,
   output logic [eht_pkg::BUCKET_BITS-1:0] bucket
);
   import eht_pkg::*;

   logic [63:0] folded;

   assign folded = key.low ^ key.mid ^ {32'd0, key.top};

   always_comb begin
      bucket = '0;
      for (int i = 0; i < 8; i++) begin
         bucket = bucket ^ folded[8*i +: BUCKET_BITS];
      end
   end

endmodule

// ===== hw/rtl/eht_entry_ram.sv =====
// Entry store: key and handle of every way of every bucket, one write port and one read port.
// Depends on eht_pkg for the key type.
`timescale 1ns / 1ps

module eht_entry_ram #(
   parameter int DEPTH       = 1024,
   parameter int HANDLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  eht_pkg::eht_key_type     wr_key,
   input  logic [HANDLE_BITS-1:0]   wr_handle,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output eht_pkg::eht_key_type     rd_key,
   output logic [HANDLE_BITS-1:0]   rd_handle
);
   import eht_pkg::*;

   eht_key_type            key_mem [DEPTH];
   logic [HANDLE_BITS-1:0] handle_mem [DEPTH];
   eht_key_type            rd_key_ff;
   logic [HANDLE_BITS-1:0] rd_handle_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]    <= wr_key;
         handle_mem[wr_addr] <= wr_handle;
      end
      if (rd_en) begin
         rd_key_ff    <= key_mem[rd_addr];
         rd_handle_ff <= handle_mem[rd_addr];
      end
   end

   assign rd_key    = rd_key_ff;
   assign rd_handle = rd_handle_ff;

endmodule

// ===== hw/rtl/eht_valid_ram.sv =====
// Valid store: one row of way valid bits for each bucket.
// Depends on eht_pkg for the bucket count and width.
`timescale 1ns / 1ps

module eht_valid_ram #(
   parameter int WAYS = 4
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [eht_pkg::BUCKET_BITS-1:0] wr_addr,
   input  logic [WAYS-1:0]                 wr_row,
   input  logic                            rd_en,
   input  logic [eht_pkg::BUCKET_BITS-1:0] rd_addr,
   output logic [WAYS-1:0]                 rd_row
);
   import eht_pkg::*;

   logic [WAYS-1:0] row_mem [BUCKETS];
   logic [WAYS-1:0] rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= row_mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

// ===== hw/rtl/eid_hash_table.sv =====
// Exact-match table keyed by a 20-byte endpoint identifier, with 256 buckets of WAYS
// entries each. A request on req_ch carries a command (lookup, insert or delete), the
// key and, for an insert, a handle; it is taken when valid and ready are both high.
// Each request yields one response on rsp_ch: found, the stored handle and a status.
// A request is taken only while the sequencer is idle. The accepting cycle reads the
// bucket's valid row and its first way; one key comparator then inspects one way per
// cycle, and a final write state updates the stores and loads the response register.
// The sequencer then returns to idle, so no new request is taken before the last one
// has left the write state; the single comparator and the one read port of the entry
// store set this pace. If the receiver holds ready low, the finished request waits in
// the write state until the response register is free.
// After reset the valid store is cleared one bucket row a cycle while ready stays low.
// Key and handle storage is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module eid_hash_table #(
   parameter int WAYS        = 4,
   parameter int HANDLE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   eht_req_if.sink    req_ch,
   eht_rsp_if.source  rsp_ch
);
   import eht_pkg::*;

   localparam int ENTRIES  = BUCKETS * WAYS;
   localparam int ENTRY_AW = $clog2(ENTRIES);
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam logic [BUCKET_BITS-1:0] LAST_ROW = BUCKET_BITS'(BUCKETS - 1);
   localparam logic [WAY_W-1:0]       LAST_WAY = WAY_W'(WAYS - 1);

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_WRITE} state_type;

   function automatic logic [ENTRY_AW-1:0] entry_addr(input logic [BUCKET_BITS-1:0] b,
                                                       input logic [WAY_W-1:0] w);
      return ENTRY_AW'(int'(b) * WAYS + int'(w));
   endfunction

   function automatic logic [WAYS-1:0] way_bit(input logic [WAY_W-1:0] w);
      return WAYS'(1) << w;
   endfunction

   state_type               state_ff, state_in;
   logic [BUCKET_BITS-1:0]  clr_ff, clr_in;
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   eht_key_type             key_ff, key_in;
   logic [HANDLE_BITS-1:0]  handle_ff, handle_in;
   logic [BUCKET_BITS-1:0]  bucket_ff, bucket_in;
   logic [WAY_W-1:0]        way_ff, way_in;
   logic                    hit_ff, hit_in;
   logic [WAY_W-1:0]        hit_way_ff, hit_way_in;
   logic                    free_ff, free_in;
   logic [WAY_W-1:0]        free_way_ff, free_way_in;
   logic [HANDLE_BITS-1:0]  hout_ff, hout_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [HANDLE_W-1:0]     rsp_handle_ff, rsp_handle_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   eht_key_type             req_key;
   logic [BUCKET_BITS-1:0]  req_bucket;
   logic                    accept;

   logic                    vr_we, vr_re;
   logic [BUCKET_BITS-1:0]  vr_waddr, vr_raddr;
   logic [WAYS-1:0]         vr_wrow, vr_rrow;

   logic                    ent_we, ent_re;
   logic [ENTRY_AW-1:0]     ent_waddr, ent_raddr;
   eht_key_type             ent_rkey;
   logic [HANDLE_BITS-1:0]  ent_rhandle;
   logic                    key_eq;

   assign req_key.low = req_ch.key_low;
   assign req_key.mid = req_ch.key_mid;
   assign req_key.top = req_ch.key_top;

   eht_hash u_hash (
      .key    (req_key),
      .bucket (req_bucket)
   );

   eht_valid_ram #(.WAYS(WAYS)) u_valid_ram (
      .clock   (clock),
      .wr_en   (vr_we),
      .wr_addr (vr_waddr),
      .wr_row  (vr_wrow),
      .rd_en   (vr_re),
      .rd_addr (vr_raddr),
      .rd_row  (vr_rrow)
   );

   eht_entry_ram #(.DEPTH(ENTRIES), .HANDLE_BITS(HANDLE_BITS)) u_entry_ram (
      .clock     (clock),
      .wr_en     (ent_we),
      .wr_addr   (ent_waddr),
      .wr_key    (key_ff),
      .wr_handle (handle_ff),
      .rd_en     (ent_re),
      .rd_addr   (ent_raddr),
      .rd_key    (ent_rkey),
      .rd_handle (ent_rhandle)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign key_eq       = (ent_rkey == key_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      handle_in     = handle_ff;
      bucket_in     = bucket_ff;
      way_in        = way_ff;
      hit_in        = hit_ff;
      hit_way_in    = hit_way_ff;
      free_in       = free_ff;
      free_way_in   = free_way_ff;
      hout_in       = hout_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      vr_we         = 1'b0;
      vr_waddr      = bucket_ff;
      vr_wrow       = vr_rrow;
      vr_re         = 1'b0;
      vr_raddr      = req_bucket;
      ent_we        = 1'b0;
      ent_waddr     = entry_addr(bucket_ff, free_way_ff);
      ent_re        = 1'b0;
      ent_raddr     = entry_addr(req_bucket, '0);

      unique case (state_ff)
         S_CLEAR: begin
            vr_we    = 1'b1;
            vr_waddr = clr_ff;
            vr_wrow  = '0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == LAST_ROW) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_ch.cmd;
               key_in    = req_key;
               handle_in = HANDLE_BITS'(req_ch.handle_in);
               bucket_in = req_bucket;
               vr_re     = 1'b1;
               ent_re    = 1'b1;
               way_in    = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (vr_rrow[way_ff]) begin
               if (!hit_ff && key_eq) begin
                  hit_in     = 1'b1;
                  hit_way_in = way_ff;
                  hout_in    = ent_rhandle;
               end
            end else if (!free_ff) begin
               free_in     = 1'b1;
               free_way_in = way_ff;
            end
            if (way_ff == LAST_WAY) begin
               state_in = S_WRITE;
            end else begin
               way_in    = way_ff + 1'b1;
               ent_re    = 1'b1;
               ent_raddr = entry_addr(bucket_ff, way_ff + 1'b1);
            end
         end
         S_WRITE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = hit_ff;
               rsp_handle_in = hit_ff ? HANDLE_W'(hout_ff) : '0;
               state_in      = S_IDLE;
               unique case (cmd_ff)
                  CMD_INSERT: begin
                     if (hit_ff) begin
                        rsp_status_in = ST_DUP;
                     end else if (!free_ff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ent_we        = 1'b1;
                        vr_we         = 1'b1;
                        vr_wrow       = vr_rrow | way_bit(free_way_ff);
                        rsp_status_in = ST_DONE;
                     end
                  end
                  CMD_DELETE: begin
                     if (hit_ff) begin
                        vr_we         = 1'b1;
                        vr_wrow       = vr_rrow & ~way_bit(hit_way_ff);
                        rsp_status_in = ST_DONE;
                     end else begin
                        rsp_status_in = ST_MISS;
                     end
                  end
                  default: begin
                     rsp_status_in = hit_ff ? ST_DONE : ST_MISS;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      handle_ff     <= handle_in;
      bucket_ff     <= bucket_in;
      way_ff        <= way_in;
      hit_way_ff    <= hit_way_in;
      free_way_ff   <= free_way_in;
      hout_ff       <= hout_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.handle_out = rsp_handle_ff;
   assign rsp_ch.status     = rsp_status_ff;

   `EHT_ASSERT(a_accept_starts_scan, clock, reset, accept |=> (state_ff == S_SCAN), "request taken but scan not started")
   `EHT_ASSERT(a_rsp_from_write, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_WRITE), "response raised outside the write cycle")
   `EHT_ASSERT(a_way_in_range, clock, reset, (state_ff == S_SCAN) |-> (int'(way_ff) < WAYS), "way counter beyond the bucket")
   `EHT_ASSERT(a_dup_is_found, clock, reset, (rsp_valid_ff && (rsp_status_ff == ST_DUP)) |-> rsp_found_ff, "duplicate insert reported without a hit")

endmodule
